// ===== hdl/pps_pkg.sv =====
// Shared types, constants and the queue ordering function for the
// preemptive priority scheduler. No dependencies.
`timescale 1ns / 1ps

package pps_pkg;

  localparam int QUEUE_DEPTH_DEF = 32;
  localparam int TIME_W          = 40;

  localparam logic FUNC_ARRIVE   = 1'b0;
  localparam logic FUNC_DRAIN    = 1'b1;
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef struct packed {
    logic        func;
    logic [15:0] job_id;
    logic [39:0] arrival_time;
    logic [23:0] run_time;
    logic [7:0]  job_priority;
  } job_t;

  typedef struct packed {
    logic        status;
    logic [15:0] done_id;
    logic [39:0] end_tick;
    logic        last;
  } done_t;

  // one queued or running job
  typedef struct packed {
    logic [15:0] id;
    logic [39:0] arrival;
    logic [7:0]  pri;
    logic [23:0] remaining;
  } entry_t;

  // best-so-far travelling down the cell row
  typedef struct packed {
    logic   valid;
    entry_t e;
  } cand_t;

  typedef struct packed {
    logic shift;  // take the neighbour's entry
    logic load;   // take the load data
  } cell_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETTLE,
    S_SEARCH,
    S_APPLY,
    S_LOOP,
    S_FIN,
    S_CHK,
    S_ARRIVE,
    S_END
  } state_t;

  // a strictly beats b: higher priority, then earlier arrival, then lower id
  function automatic logic beats(entry_t a, entry_t b);
    logic [63:0] ka;
    logic [63:0] kb;
    ka = {a.pri, ~a.arrival, ~a.id};
    kb = {b.pri, ~b.arrival, ~b.id};
    return ka > kb;
  endfunction

endpackage

// ===== hdl/pps_cell.sv =====
// One queue slot: holds an entry, shifts/loads on command, and runs one
// registered stage of the head search. Depends on pps_pkg.
`timescale 1ns / 1ps

module pps_cell #(
  parameter int IW  = 5,
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  pps_pkg::cell_ctl_t ctl,
  input  logic              occupied,
  input  pps_pkg::entry_t   neighbour,
  input  pps_pkg::entry_t   load_data,
  input  pps_pkg::cand_t    best_in,
  input  logic [IW-1:0]     best_in_idx,
  output pps_pkg::entry_t   entry,
  output pps_pkg::cand_t    best_out,
  output logic [IW-1:0]     best_out_idx
);

  logic take_own;

  // earlier slot wins ties, so replace only on a strict win
  assign take_own = occupied && (!best_in.valid || pps_pkg::beats(entry, best_in.e));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= load_data;
    end else if (ctl.shift) begin
      entry <= neighbour;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_out.valid <= 1'b0;
    end else begin
      best_out.valid <= take_own | best_in.valid;
    end
    if (take_own) begin
      best_out.e   <= entry;
      best_out_idx <= IW'(IDX);
    end else begin
      best_out.e   <= best_in.e;
      best_out_idx <= best_in_idx;
    end
  end

endmodule

// ===== hdl/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler: one core, a row of queue cells and the
// sequencer that settles choices and retires jobs. Depends on pps_pkg, pps_cell.
//
// Usage:
//   Requests enter on job/job_valid/job_stall: an arrival (func 0) or a drain
//   (func 1). Results leave on done/done_valid/done_stall, one per completed
//   or rejected job, with last set on the final result of a request. A request
//   that produces nothing gives no result.
//   An arrival at the current time stamp goes straight to the arrive step; a
//   drain, or an arrival that moves the clock, first settles the open choice.
//   Each head search walks the cells and then applies its result, and each
//   retired job passes through finish, check and loop.
//   One request is in work at a time; job_stall is high until it is done.
//   The last result of each request is held until the next result or the end
//   of the request is known, so that last can be set.
//   Reset (rst, synchronous) empties the queue, idles the core and sets the
//   clock to zero. No clearing pass is needed.
//   When the receiver stalls, the sequencer waits at the next result and the
//   output register holds its value.
`timescale 1ns / 1ps

module preemptive_priority_scheduler #(
  parameter int QUEUE_DEPTH = pps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_stall,
  input  pps_pkg::job_t  job,
  output logic           done_valid,
  input  logic           done_stall,
  output pps_pkg::done_t done
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  pps_pkg::state_t state, state_next;

  logic [IW-1:0]   cnt;
  logic [39:0]     clock_now;
  logic            busy;
  logic            pending;
  pps_pkg::entry_t run;
  logic [CW-1:0]   count;
  logic            drain_mode;
  logic            take_mode;
  logic [15:0]     cur_id;
  logic [39:0]     cur_t;
  logic [23:0]     cur_rt;
  logic [7:0]      cur_pr;
  logic [39:0]     fin;
  logic            held_v;
  pps_pkg::done_t  held;

  pps_pkg::entry_t    entries [QUEUE_DEPTH];
  pps_pkg::cand_t     cand    [QUEUE_DEPTH];
  logic [IW-1:0]      cidx    [QUEUE_DEPTH];
  pps_pkg::cell_ctl_t cctl    [QUEUE_DEPTH];

  pps_pkg::entry_t head;
  logic [IW-1:0]   head_idx;

  logic            out_free;
  logic            full;
  logic [39:0]     t_eff;
  logic [40:0]     sum;
  logic [39:0]     fin_sat;
  logic [39:0]     diff;
  logic            retire;
  logic            do_take;
  logic            do_swap;
  logic            do_remove;
  logic            do_load;
  logic [CW-1:0]   load_idx;
  pps_pkg::entry_t load_data;
  logic            produce;
  pps_pkg::done_t  prod_val;
  logic            flush;

  assign head     = cand[QUEUE_DEPTH-1].e;
  assign head_idx = cidx[QUEUE_DEPTH-1];

  // ---------------------------------------------------------------- cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    pps_pkg::cand_t  bin;
    logic [IW-1:0]   bin_idx;
    pps_pkg::entry_t nb;

    if (i == 0) begin : g_first
      assign bin     = '0;
      assign bin_idx = '0;
    end else begin : g_rest
      assign bin     = cand[i-1];
      assign bin_idx = cidx[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nb = load_data;
    end else begin : g_body
      assign nb = entries[i+1];
    end

    assign cctl[i].shift = do_remove && (IW'(i) >= head_idx) && (CW'(i + 1) < count);
    assign cctl[i].load  = do_load && (CW'(i) == load_idx);

    pps_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl          (cctl[i]),
      .occupied     (CW'(i) < count),
      .neighbour    (nb),
      .load_data    (load_data),
      .best_in      (bin),
      .best_in_idx  (bin_idx),
      .entry        (entries[i]),
      .best_out     (cand[i]),
      .best_out_idx (cidx[i])
    );
  end

  // ------------------------------------------------------------ control
  always_comb begin
    out_free  = !done_valid || !done_stall;
    full      = (count == CW'(QUEUE_DEPTH));
    t_eff     = (job.arrival_time < clock_now) ? clock_now : job.arrival_time;
    sum       = {1'b0, clock_now} + 41'(run.remaining);
    fin_sat   = sum[40] ? '1 : sum[39:0];
    diff      = cur_t - clock_now;
    retire    = drain_mode || (fin <= cur_t);
    job_stall = (state != pps_pkg::S_IDLE);

    do_take   = (state == pps_pkg::S_APPLY) && (take_mode || !busy);
    do_swap   = (state == pps_pkg::S_APPLY) && !do_take && (head.pri > run.pri);
    do_remove = do_take || do_swap;

    do_load   = 1'b0;
    load_idx  = count;
    load_data = run;
    if (do_swap) begin
      do_load  = 1'b1;
      load_idx = count - CW'(1);
    end else if ((state == pps_pkg::S_ARRIVE) && !full) begin
      do_load   = 1'b1;
      load_data = '{id: cur_id, arrival: cur_t, pri: cur_pr, remaining: cur_rt};
    end

    produce  = 1'b0;
    prod_val = '{status: pps_pkg::STATUS_DONE, done_id: run.id, end_tick: fin, last: 1'b0};
    if ((state == pps_pkg::S_CHK) && retire && out_free) begin
      produce = 1'b1;
    end else if ((state == pps_pkg::S_ARRIVE) && full && out_free) begin
      produce  = 1'b1;
      prod_val = '{status: pps_pkg::STATUS_REJECT, done_id: cur_id,
                   end_tick: cur_t, last: 1'b0};
    end

    flush = (state == pps_pkg::S_END) && held_v && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pps_pkg::S_IDLE: begin
        if (job_valid) begin
          if (job.func == pps_pkg::FUNC_DRAIN || t_eff > clock_now) begin
            state_next = pps_pkg::S_SETTLE;
          end else begin
            state_next = pps_pkg::S_ARRIVE;
          end
        end
      end
      pps_pkg::S_SETTLE: begin
        state_next = (pending && count != '0) ? pps_pkg::S_SEARCH : pps_pkg::S_LOOP;
      end
      pps_pkg::S_SEARCH: begin
        if (cnt == '0) begin
          state_next = pps_pkg::S_APPLY;
        end
      end
      pps_pkg::S_APPLY: begin
        state_next = take_mode ? pps_pkg::S_FIN : pps_pkg::S_LOOP;
      end
      pps_pkg::S_LOOP: begin
        if (busy) begin
          state_next = pps_pkg::S_FIN;
        end else if (count != '0) begin
          state_next = pps_pkg::S_SEARCH;
        end else begin
          state_next = drain_mode ? pps_pkg::S_END : pps_pkg::S_ARRIVE;
        end
      end
      pps_pkg::S_FIN: begin
        state_next = pps_pkg::S_CHK;
      end
      pps_pkg::S_CHK: begin
        if (!retire) begin
          state_next = pps_pkg::S_ARRIVE;
        end else if (out_free) begin
          if (!drain_mode && fin == cur_t) begin
            state_next = pps_pkg::S_ARRIVE;
          end else begin
            state_next = pps_pkg::S_LOOP;
          end
        end
      end
      pps_pkg::S_ARRIVE: begin
        if (!full || out_free) begin
          state_next = pps_pkg::S_END;
        end
      end
      pps_pkg::S_END: begin
        if (!held_v || out_free) begin
          state_next = pps_pkg::S_IDLE;
        end
      end
      default: state_next = pps_pkg::S_IDLE;
    endcase
  end

  // ------------------------------------------------------------ datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pps_pkg::S_IDLE;
      clock_now  <= '0;
      busy       <= 1'b0;
      pending    <= 1'b0;
      count      <= '0;
      held_v     <= 1'b0;
      done_valid <= 1'b0;
    end else begin
      state <= state_next;

      case (state)
        pps_pkg::S_IDLE: begin
          if (job_valid) begin
            drain_mode <= job.func;
            cur_id     <= job.job_id;
            cur_t      <= t_eff;
            cur_rt     <= job.run_time;
            cur_pr     <= job.job_priority;
          end
        end
        pps_pkg::S_SETTLE: begin
          take_mode <= 1'b0;
          cnt       <= IW'(QUEUE_DEPTH - 1);
          if (!(pending && count != '0)) begin
            pending <= 1'b0;
          end
        end
        pps_pkg::S_SEARCH: begin
          cnt <= cnt - IW'(1);
        end
        pps_pkg::S_APPLY: begin
          if (do_remove) begin
            run  <= head;
            busy <= 1'b1;
          end
          if (do_take) begin
            count <= count - CW'(1);
          end
          if (!take_mode) begin
            pending <= 1'b0;
          end
        end
        pps_pkg::S_LOOP: begin
          take_mode <= 1'b1;
          cnt       <= IW'(QUEUE_DEPTH - 1);
          if (!busy && count == '0 && !drain_mode) begin
            clock_now <= cur_t;
          end
        end
        pps_pkg::S_FIN: begin
          fin <= fin_sat;
        end
        pps_pkg::S_CHK: begin
          if (produce) begin
            clock_now <= fin;
            busy      <= 1'b0;
          end else if (!retire) begin
            // job still runs at the new time stamp
            run.remaining <= run.remaining - diff[23:0];
            clock_now     <= cur_t;
          end
        end
        pps_pkg::S_ARRIVE: begin
          if (!full) begin
            count   <= count + CW'(1);
            pending <= 1'b1;
          end
        end
        default: ;
      endcase

      // one result is held back so that last can be set on the final one
      if (produce) begin
        held   <= prod_val;
        held_v <= 1'b1;
      end else if (flush) begin
        held_v <= 1'b0;
      end

      if (produce && held_v) begin
        done       <= held;
        done_valid <= 1'b1;
      end else if (flush) begin
        done       <= '{status: held.status, done_id: held.done_id,
                        end_tick: held.end_tick, last: 1'b1};
        done_valid <= 1'b1;
      end else if (done_valid && !done_stall) begin
        done_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== sim/sched_checker.sv =====
// Checker for the preemptive priority scheduler: watches both channels, keeps
// its own scheduler state, and compares every result. Depends on pps_pkg.
`timescale 1ns / 1ps

module sched_checker #(
  parameter int DEPTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  logic           job_stall,
  input  pps_pkg::job_t  job,
  input  logic           done_valid,
  input  logic           done_stall,
  input  pps_pkg::done_t done,
  output int             fail_count,
  output int             pending
);

  localparam logic [39:0] TIME_MAX = 40'hFF_FFFF_FFFF;

  logic [39:0]     now;
  logic            busy;
  logic            choice_open;
  pps_pkg::entry_t running;
  pps_pkg::entry_t ready_q[$];
  pps_pkg::done_t  expected_done[$];
  pps_pkg::done_t  step_out[$];

  assign pending = expected_done.size();

  function automatic bit ahead(pps_pkg::entry_t a, pps_pkg::entry_t b);
    if (a.pri != b.pri) return a.pri > b.pri;
    if (a.arrival != b.arrival) return a.arrival < b.arrival;
    return a.id < b.id;
  endfunction

  function automatic int best_index();
    int b;
    b = 0;
    for (int i = 1; i < ready_q.size(); i++)
      if (ahead(ready_q[i], ready_q[b])) b = i;
    return b;
  endfunction

  task automatic take_best();
    int h;
    h = best_index();
    running = ready_q[h];
    busy = 1'b1;
    ready_q.delete(h);
  endtask

  task automatic record(logic st, logic [15:0] id, logic [39:0] t);
    pps_pkg::done_t d;
    d.status = st;
    d.done_id = id;
    d.end_tick = t;
    d.last = 1'b0;
    step_out.insert(step_out.size(), d);
  endtask

  function automatic logic [39:0] finish_at();
    logic [40:0] f;
    f = {1'b0, now} + running.remaining;
    return f > TIME_MAX ? TIME_MAX : f[39:0];
  endfunction

  task automatic settle_choice();
    pps_pkg::entry_t prev;
    if (choice_open && ready_q.size() > 0) begin
      if (!busy) begin
        take_best();
      end else if (ready_q[best_index()].pri > running.pri) begin
        prev = running;
        take_best();
        ready_q.insert(ready_q.size(), prev);
      end
    end
    choice_open = 1'b0;
  endtask

  // run forward to t (drain_all: until nothing is left)
  task automatic run_to(logic [39:0] t, bit drain_all);
    logic [39:0] f;
    forever begin
      if (!busy) begin
        if (ready_q.size() == 0) begin
          if (!drain_all) now = t;
          return;
        end
        take_best();
      end
      f = finish_at();
      if (drain_all || f <= t) begin
        record(pps_pkg::STATUS_DONE, running.id, f);
        now = f;
        busy = 1'b0;
        if (!drain_all && f == t) return;
      end else begin
        running.remaining -= 24'(t - now);
        now = t;
        return;
      end
    end
  endtask

  task automatic predict(pps_pkg::job_t j);
    logic [39:0] t;
    pps_pkg::entry_t e;
    step_out = {};
    if (j.func == pps_pkg::FUNC_DRAIN) begin
      settle_choice();
      run_to('0, 1);
    end else begin
      t = j.arrival_time < now ? now : j.arrival_time;
      if (t > now) begin
        settle_choice();
        run_to(t, 0);
      end
      if (ready_q.size() >= DEPTH) begin
        record(pps_pkg::STATUS_REJECT, j.job_id, t);
      end else begin
        e.id = j.job_id;
        e.arrival = t;
        e.pri = j.job_priority;
        e.remaining = j.run_time;
        ready_q.insert(ready_q.size(), e);
        choice_open = 1'b1;
      end
    end
    if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
    foreach (step_out[i]) expected_done.insert(expected_done.size(), step_out[i]);
  endtask

  task automatic mismatch(pps_pkg::done_t exp_d, pps_pkg::done_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch: exp st/id/t/last %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
               exp_d.status, exp_d.done_id, exp_d.end_tick, exp_d.last,
               got.status, got.done_id, got.end_tick, got.last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      now = '0;
      busy = 1'b0;
      choice_open = 1'b0;
      running = '0;
      ready_q = {};
      expected_done = {};
      fail_count = 0;
    end else begin
      if (done_valid && !done_stall) begin
        if (expected_done.size() == 0) begin
          mismatch('0, done);
        end else begin
          if (expected_done[0] !== done) mismatch(expected_done[0], done);
          void'(expected_done.pop_front());
        end
      end
      if (job_valid && !job_stall) predict(job);
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Stimulus and verdict for the preemptive priority scheduler: directed and
// random requests under several idling phases. Depends on pps_pkg, sched_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH = 32;

  logic           clk;
  logic           rst;
  logic           job_valid;
  logic           job_stall;
  pps_pkg::job_t  job;
  logic           done_valid;
  logic           done_stall;
  pps_pkg::done_t done;
  int    fail_count;
  int    pending;
  int    send_idle_pct;
  int    recv_stall_pct;
  bit    hold_off;
  logic [39:0] t_base;
  longint cycles;

  preemptive_priority_scheduler #(.QUEUE_DEPTH(DEPTH)) dut (.*);

  sched_checker #(.DEPTH(DEPTH)) checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 3000000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (rst) done_stall <= 1'b0;
    else done_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // valid stays up after acceptance so that requests can follow back to back
  task automatic send(pps_pkg::job_t j);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      job_valid <= 1'b0;
      @(posedge clk);
    end
    job <= j;
    job_valid <= 1'b1;
    @(posedge clk);
    while (job_stall) @(posedge clk);
  endtask

  // drop valid after the last request of a sequence
  task automatic pause_input();
    job_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic arrive(logic [15:0] id, logic [39:0] t, logic [23:0] rt, logic [7:0] p);
    pps_pkg::job_t j;
    j.func = pps_pkg::FUNC_ARRIVE;
    j.job_id = id;
    j.arrival_time = t;
    j.run_time = rt;
    j.job_priority = p;
    send(j);
  endtask

  task automatic drain_all();
    pps_pkg::job_t j;
    j = '0;
    j.func = pps_pkg::FUNC_DRAIN;
    j.job_id = 16'($urandom);
    j.arrival_time = {8'($urandom), 32'($urandom)};
    j.run_time = 24'($urandom);
    j.job_priority = 8'($urandom);
    send(j);
  endtask

  // a burst of mostly well-formed arrivals with random content
  task automatic random_burst(int n);
    logic [23:0] rt;
    logic [7:0]  p;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: t_base = t_base - 40'($urandom_range(20));   // late arrival
        1, 2, 3: ;                                      // same time stamp
        default: t_base = t_base + 40'($urandom_range(40));
      endcase
      rt = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(30));
      p = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      if ($urandom_range(29) == 0) drain_all();
      else arrive(16'($urandom), t_base, rt, p);
    end
    drain_all();
  endtask

  initial begin
    rst = 1'b1;
    job_valid = 1'b0;
    job = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b0;
    t_base = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty drain, extremes, ties, zero run time, preemption
    drain_all();
    arrive(16'hFFFF, 40'd5, 24'd0, 8'hFF);
    arrive(16'h0000, 40'd5, 24'd3, 8'h00);
    arrive(16'h0002, 40'd5, 24'd3, 8'h00);
    arrive(16'h0001, 40'd5, 24'd3, 8'h00);
    arrive(16'h0010, 40'd6, 24'd10, 8'd1);
    arrive(16'h0011, 40'd2, 24'd4, 8'd9);       // in the past
    arrive(16'h0012, 40'd20, 24'd1, 8'd9);      // exactly at a finish
    arrive(16'h0013, 40'd30, 24'hFFFFFF, 8'd1);
    drain_all();
    arrive(16'h0020, 40'hFF_FFFF_FF00, 24'hFFFFFF, 8'd3);   // saturation
    arrive(16'h0021, 40'hFF_FFFF_FFFF, 24'hFFFFFF, 8'd7);
    drain_all();
    // fill past the queue to get rejections
    for (int i = 0; i < DEPTH + 3; i++)
      arrive(16'(16'h100 + i), 40'hFF_FFFF_FFFF, 24'd1, 8'($urandom));
    drain_all();

    // reset the time base would break ordering; clock sits at maximum, so
    // remaining arrivals are all late and taken as now
    t_base = 40'hFF_FFFF_FFFF;
    random_burst(60);
    send_idle_pct = 79;
    random_burst(60);
    send_idle_pct = 0;
    recv_stall_pct = 79;
    random_burst(60);
    send_idle_pct = 7;
    recv_stall_pct = 7;
    random_burst(60);

    // long hold-off so the block backs up its input
    fork
      begin
        hold_off = 1'b1;
        for (int c = 0; c < 3000; c++) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        random_burst(60);
        pause_input();
      end
    join
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_burst(60);
    pause_input();

    while (pending > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pps_pkg.sv
hdl/pps_cell.sv
hdl/preemptive_priority_scheduler.sv
sim/sched_checker.sv
sim/testbench.sv
